// ===== src/nrmc_pkg.sv =====
// shared constants, types and helpers for the rmc sentence parser
`timescale 1ns / 1ps

package nrmc_pkg;

  localparam int CHAR_W = 8;
  localparam int ACC_W  = 32;
  localparam int CNT_W  = 4;
  localparam int LAT_W  = 27;
  localparam int LON_W  = 28;
  localparam int HDG_W  = 9;
  localparam int SPD_W  = 16;

  // characters of interest
  localparam logic [CHAR_W-1:0] CHAR_DOLLAR = 8'h24;
  localparam logic [CHAR_W-1:0] CHAR_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CHAR_DOT    = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_A      = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_V      = 8'h56;

  // comma counts that select a field
  localparam logic [CNT_W-1:0] CNT_FIX     = 4'd2;
  localparam logic [CNT_W-1:0] CNT_LAT     = 4'd3;
  localparam logic [CNT_W-1:0] CNT_LAT_END = 4'd4;
  localparam logic [CNT_W-1:0] CNT_LON     = 4'd5;
  localparam logic [CNT_W-1:0] CNT_LON_END = 4'd6;
  localparam logic [CNT_W-1:0] CNT_SPD     = 4'd7;
  localparam logic [CNT_W-1:0] CNT_HDG     = 4'd8;
  localparam logic [CNT_W-1:0] CNT_EMIT    = 4'd9;
  localparam logic [CNT_W-1:0] CNT_DONE    = 4'd10;
  localparam logic [CNT_W-1:0] CNT_MAX     = 4'd15;

  localparam logic [LAT_W-1:0] LAT_MAX_UDEG = 27'd90000000;
  localparam logic [LON_W-1:0] LON_MAX_UDEG = 28'd180000000;

  // degree split: floor(d / 1e6) = (d * DEG_MUL) >> DEG_SHIFT for 32-bit d
  localparam logic [19:0] UDEG_PER_DEG = 20'd1000000;
  localparam logic [30:0] DEG_MUL      = 31'd1125899907;
  localparam int          DEG_SHIFT    = 50;
  // floor(x / 3) = (x * DIV3_MUL) >> DIV3_SHIFT for 23-bit x
  localparam logic [22:0] DIV3_MUL     = 23'd5592406;
  localparam int          DIV3_SHIFT   = 24;

  // heading: digits at or above this give the saturated value
  localparam logic [ACC_W-1:0] HDG_SAT_DIGITS = 32'd3590;
  localparam logic [HDG_W-1:0] HDG_MAX_DEG    = 9'd359;
  localparam logic [HDG_W-1:0] FULL_TURN_DEG  = 9'd360;
  // floor(h / 10) = (h * DIV10_MUL) >> DIV10_SHIFT for 12-bit h
  localparam logic [11:0] DIV10_MUL   = 12'd3277;
  localparam int          DIV10_SHIFT = 15;

  // speed: knots*10 * 1852 / 36000 = s * 463 / 9000
  localparam logic [ACC_W-1:0] SPD_SAT_DIGITS = 32'd1273918;
  localparam logic [SPD_W-1:0] SPD_MAX        = 16'hFFFF;
  localparam logic [8:0]       SPD_NUM        = 9'd463;
  // floor(p / 9000) = (p * DIV9K_MUL) >> DIV9K_SHIFT for 30-bit p
  localparam logic [30:0]      DIV9K_MUL      = 31'd1954687339;
  localparam int               DIV9K_SHIFT    = 44;

  typedef struct packed {
    logic             vld;
    logic             lon;
    logic [ACC_W-1:0] digits;
  } conv_req_t;

  // one numeric field step: comma clears, dot is skipped, else acc*10 + (c - '0')
  function automatic logic [ACC_W-1:0] acc_next(input logic [ACC_W-1:0] acc,
                                                input logic [CHAR_W-1:0] ch);
    logic [ACC_W-1:0] scaled;
    logic [ACC_W-1:0] res;
    scaled = (acc << 3) + (acc << 1);
    priority if (ch == CHAR_COMMA) begin
      res = '0;
    end else if (ch == CHAR_DOT) begin
      res = acc;
    end else begin
      res = scaled + {{(ACC_W-CHAR_W){1'b0}}, ch} - {{(ACC_W-CHAR_W){1'b0}}, CHAR_ZERO};
    end
    return res;
  endfunction

endpackage

// ===== src/nrmc_conv.sv =====
// pipelined ddmm.mmmm to microdegree conversion, holds latitude and longitude
`timescale 1ns / 1ps

module nrmc_conv
  import nrmc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  conv_req_t        req,
  output logic [LAT_W-1:0] lat_value,
  output logic [LON_W-1:0] lon_value
);

  logic             v1_r, v2_r, v3_r, v4_r;
  logic             lon1_r, lon2_r, lon3_r, lon4_r;
  logic [ACC_W-1:0] d1_r, d2_r;
  logic [12:0]      q2_r;
  logic [ACC_W-1:0] base3_r, base4_r;
  logic [19:0]      rem3_r;
  logic [20:0]      frac4_r;
  logic [LAT_W-1:0] lat_value_r, lat_value_nxt;
  logic [LON_W-1:0] lon_value_r, lon_value_nxt;

  logic [62:0]      prod;
  logic [32:0]      base_full;
  logic [ACC_W-1:0] rem_full;
  logic [22:0]      x5;
  logic [45:0]      t3;
  logic [32:0]      sum;

  assign prod      = {31'd0, d1_r} * {32'd0, DEG_MUL};
  assign base_full = {20'd0, q2_r} * {13'd0, UDEG_PER_DEG};
  assign rem_full  = d2_r - base_full[ACC_W-1:0];
  assign x5        = {1'b0, rem3_r, 2'b00} + {3'd0, rem3_r};
  assign t3        = {23'd0, x5} * {23'd0, DIV3_MUL};
  assign sum       = {1'b0, base4_r} + {12'd0, frac4_r};

  always_comb begin
    lat_value_nxt = lat_value_r;
    lon_value_nxt = lon_value_r;
    if (v4_r && !lon4_r) begin
      lat_value_nxt = (sum > {6'd0, LAT_MAX_UDEG}) ? LAT_MAX_UDEG : sum[LAT_W-1:0];
    end
    if (v4_r && lon4_r) begin
      lon_value_nxt = (sum > {5'd0, LON_MAX_UDEG}) ? LON_MAX_UDEG : sum[LON_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      lat_value_r <= '0;
      lon_value_r <= '0;
    end else begin
      v1_r <= req.vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      lat_value_r <= lat_value_nxt;
      lon_value_r <= lon_value_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lon1_r  <= req.lon;
    d1_r    <= req.digits;
    lon2_r  <= lon1_r;
    d2_r    <= d1_r;
    q2_r    <= prod[62:DEG_SHIFT];
    lon3_r  <= lon2_r;
    base3_r <= base_full[ACC_W-1:0];
    rem3_r  <= rem_full[19:0];
    lon4_r  <= lon3_r;
    base4_r <= base3_r;
    frac4_r <= t3[DIV3_SHIFT+20:DIV3_SHIFT];
  end

  // stored position, including a conversion written at this edge
  assign lat_value = lat_value_nxt;
  assign lon_value = lon_value_nxt;

endmodule

// ===== src/nmea_rmc_sentence_parser.sv =====
// top level: rmc character parser with result pipeline
`timescale 1ns / 1ps

// Usage
// The input channel takes one ASCII character per word (in_valid, in_stall,
// in_char_in). A '$' starts a sentence; commas select the fields. On the
// ninth comma of a sentence with fix 'A' one result word leaves on the
// output channel (out_valid, out_stall): latitude and longitude in
// microdegrees, heading and angle to north in degrees, speed in m/s.
// Throughput: one character per clock cycle while in_stall is low. Each
// character goes through an input register and is applied to the parser
// state once the first result stage is ready. After the ninth comma is
// accepted, the result word passes the input register and then the three
// result stages, which carry the speed and heading scaling, to out_valid.
// Position conversion runs in a separate unit; the second result stage
// takes the position as that unit writes it, in time even when the
// longitude is followed by three bare commas.
// Reset clears the comma count, fix flag, accumulators and stored
// position, and empties all stages. While out_stall is high the output
// word holds; the three result stages and the input register fill up and
// in_stall rises only when all of them are occupied.
module nmea_rmc_sentence_parser
  import nrmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] in_char_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [LAT_W-1:0]  out_latitude_udeg,
  output logic [LON_W-1:0]  out_longitude_udeg,
  output logic [HDG_W-1:0]  out_heading_deg,
  output logic [HDG_W-1:0]  out_north_angle_deg,
  output logic [SPD_W-1:0]  out_speed_mps
);

  // input register
  logic              v0_r;
  logic [CHAR_W-1:0] char0_r;

  // parser state
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              fix_r, fix_nxt;
  logic [ACC_W-1:0]  lat_dig_r, lat_dig_nxt;
  logic [ACC_W-1:0]  lon_dig_r, lon_dig_nxt;
  logic [ACC_W-1:0]  spd_dig_r, spd_dig_nxt;
  logic [ACC_W-1:0]  hdg_dig_r, hdg_dig_nxt;

  // result stages
  logic              v1_r, v2_r, v3_r;
  logic [LAT_W-1:0]  lat2_r, lat3_r;
  logic [LON_W-1:0]  lon2_r, lon3_r;
  logic              hsat1_r;
  logic [11:0]       h1_r;
  logic              ssat1_r, ssat2_r;
  logic [20:0]       s1_r;
  logic [HDG_W-1:0]  hdg2_r, hdg3_r;
  logic [HDG_W-1:0]  north2_r, north3_r;
  logic [29:0]       p2_r;
  logic [SPD_W-1:0]  spd3_r;

  logic              ready1, ready2, ready3;
  logic              proc, emit, in_fire;
  logic [CNT_W-1:0]  cnt_new;
  logic [ACC_W-1:0]  acc_in;
  conv_req_t         conv_req;
  logic [LAT_W-1:0]  lat_value;
  logic [LON_W-1:0]  lon_value;
  logic [23:0]       hprod;
  logic [HDG_W-1:0]  hdg_div;
  logic [60:0]       sprod;

  assign ready3   = !v3_r || !out_stall;
  assign ready2   = !v2_r || ready3;
  assign ready1   = !v1_r || ready2;
  assign proc     = v0_r && ready1;
  assign in_stall = v0_r && !ready1;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (!in_stall) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      char0_r <= in_char_in;
    end
  end

  // comma count first, then the field the new count selects
  always_comb begin
    priority if (char0_r == CHAR_DOLLAR) begin
      cnt_new = '0;
    end else if (char0_r == CHAR_COMMA && cnt_r != CNT_MAX) begin
      cnt_new = cnt_r + 1'b1;
    end else begin
      cnt_new = cnt_r;
    end
  end

  always_comb begin
    acc_in      = '0;
    fix_nxt     = fix_r;
    lat_dig_nxt = lat_dig_r;
    lon_dig_nxt = lon_dig_r;
    spd_dig_nxt = spd_dig_r;
    hdg_dig_nxt = hdg_dig_r;
    conv_req    = '{vld: 1'b0, lon: 1'b0, digits: lat_dig_r};
    unique case (cnt_new)
      CNT_FIX: begin
        if (char0_r == CHAR_A) begin
          fix_nxt = 1'b1;
        end else if (char0_r == CHAR_V) begin
          fix_nxt = 1'b0;
        end
      end
      CNT_LAT: begin
        acc_in      = lat_dig_r;
        lat_dig_nxt = acc_next(acc_in, char0_r);
      end
      CNT_LAT_END: begin
        conv_req.vld = proc && (char0_r == CHAR_COMMA);
      end
      CNT_LON: begin
        acc_in      = lon_dig_r;
        lon_dig_nxt = acc_next(acc_in, char0_r);
      end
      CNT_LON_END: begin
        conv_req = '{vld: proc && (char0_r == CHAR_COMMA), lon: 1'b1, digits: lon_dig_r};
      end
      CNT_SPD: begin
        acc_in      = spd_dig_r;
        spd_dig_nxt = acc_next(acc_in, char0_r);
      end
      CNT_HDG: begin
        acc_in      = hdg_dig_r;
        hdg_dig_nxt = acc_next(acc_in, char0_r);
      end
      default: begin
      end
    endcase
    emit    = (cnt_new == CNT_EMIT) && fix_r;
    cnt_nxt = emit ? CNT_DONE : cnt_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      fix_r     <= 1'b0;
      lat_dig_r <= '0;
      lon_dig_r <= '0;
      spd_dig_r <= '0;
      hdg_dig_r <= '0;
    end else if (proc) begin
      cnt_r     <= cnt_nxt;
      fix_r     <= fix_nxt;
      lat_dig_r <= lat_dig_nxt;
      lon_dig_r <= lon_dig_nxt;
      spd_dig_r <= spd_dig_nxt;
      hdg_dig_r <= hdg_dig_nxt;
    end
  end

  nrmc_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (conv_req),
    .lat_value (lat_value),
    .lon_value (lon_value)
  );

  // result stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ready1) begin
        v1_r <= proc && emit;
      end
      if (ready2) begin
        v2_r <= v1_r;
      end
      if (ready3) begin
        v3_r <= v2_r;
      end
    end
  end

  assign hprod   = {12'd0, h1_r} * {12'd0, DIV10_MUL};
  assign hdg_div = hprod[DIV10_SHIFT+HDG_W-1:DIV10_SHIFT];
  assign sprod   = {31'd0, p2_r} * {30'd0, DIV9K_MUL};

  always_ff @(posedge clk) begin
    if (ready1 && proc && emit) begin
      hsat1_r <= hdg_dig_r >= HDG_SAT_DIGITS;
      h1_r    <= hdg_dig_r[11:0];
      ssat1_r <= spd_dig_r >= SPD_SAT_DIGITS;
      s1_r    <= spd_dig_r[20:0];
    end
    // position is taken here: a longitude conversion still in flight at the
    // ninth comma is written no later than this stage loads
    if (ready2 && v1_r) begin
      lat2_r   <= lat_value;
      lon2_r   <= lon_value;
      hdg2_r   <= hsat1_r ? HDG_MAX_DEG : hdg_div;
      north2_r <= FULL_TURN_DEG - (hsat1_r ? HDG_MAX_DEG : hdg_div);
      ssat2_r  <= ssat1_r;
      p2_r     <= {9'd0, s1_r} * {21'd0, SPD_NUM};
    end
    if (ready3 && v2_r) begin
      lat3_r   <= lat2_r;
      lon3_r   <= lon2_r;
      hdg3_r   <= hdg2_r;
      north3_r <= north2_r;
      spd3_r   <= ssat2_r ? SPD_MAX : sprod[DIV9K_SHIFT+SPD_W-1:DIV9K_SHIFT];
    end
  end

  assign out_valid           = v3_r;
  assign out_latitude_udeg   = lat3_r;
  assign out_longitude_udeg  = lon3_r;
  assign out_heading_deg     = hdg3_r;
  assign out_north_angle_deg = north3_r;
  assign out_speed_mps       = spd3_r;

`ifndef NO_ASSERTIONS
  // heading and angle to north always add up to a full turn
  a_north_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_heading_deg} + {1'b0, out_north_angle_deg}) ==
                  {1'b0, FULL_TURN_DEG})
    else $error("heading and north angle do not sum to 360");

  a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_latitude_udeg <= LAT_MAX_UDEG) && (out_heading_deg <= HDG_MAX_DEG))
    else $error("latitude or heading out of range");

  // input is held back only while the input register waits on a full pipe
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v0_r && v1_r && v2_r && v3_r && out_stall)
    else $error("input stalled with room in the result pipe");

  // an emitted sentence moves the count past the ninth comma
  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    proc && emit |=> cnt_r == CNT_DONE)
    else $error("count not advanced after emission");
`endif

endmodule
